// ----- rtl/stp_pkg.sv -----
// Shared types and constants for the software timer pool.
`timescale 1ns / 1ps

package stp_pkg;

	localparam int TIMER_SLOTS_DEF = 8;
	localparam logic [31:0] WRAP_GUARD = 32'hFFFF_0000;

	typedef enum logic [2:0] {
		MODE_TICK     = 3'd0,
		MODE_ALLOC    = 3'd1,
		MODE_RELEASE  = 3'd2,
		MODE_QUERY    = 3'd3,
		MODE_RESTART  = 3'd4
	} stp_mode_t;

	typedef enum logic [1:0] {
		ST_FREE   = 2'd0,
		ST_IDLE   = 2'd1,
		ST_ACTIVE = 2'd2,
		ST_WRAP   = 2'd3
	} stp_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_QRD,
		S_QCMP,
		S_DONE
	} stp_state_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [2:0]  slot;
		logic [15:0] period;
	} stp_req_t;

	typedef struct packed {
		logic        ok;
		logic [2:0]  granted_slot;
		logic        running;
		logic [31:0] tick_value;
	} stp_rsp_t;

endpackage

// ----- rtl/stp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module stp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/software_timer_pool_unit.sv -----
// Top level of the software timer pool: tick counter, slot states and sequencer.
`timescale 1ns / 1ps
// Sequence: tick, restart, release and unknown modes go from transfer straight to S_DONE;
//   query goes through S_QRD and S_QCMP (straight to S_DONE for a slot out of range);
//   allocate goes through S_SCAN, which scans 1 .. TIMER_SLOTS slots.
// One request at a time: the free-slot scan checks one slot per cycle, and a query
//   waits on the registered expiry RAM read in S_QRD.
// Reset (arst_n low, asynchronous): counter zero, all slots free, no result pending.
//   Expiry entries are not cleared; allocate writes one before it can be read.

module software_timer_pool_unit
	import stp_pkg::*;
#(
	parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  stp_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output stp_rsp_t rsp
);

	localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(TIMER_SLOTS - 1);

	stp_state_t  state_q, state_d;
	stp_status_t status_q [TIMER_SLOTS];
	logic [31:0] cnt_q;
	logic        rsp_valid_q;
	stp_rsp_t    rsp_q;

	// per-request working registers
	logic [15:0] period_q;
	logic [IW-1:0] idx_q;
	logic        res_ok_q;
	logic [2:0]  res_slot_q;
	logic        res_run_q;

	logic        req_xfer;
	logic        out_free;
	logic        slot_in_range;
	logic [6:0]  slot_ext;
	logic [6:0]  idx_ext;
	logic [IW-1:0] slot_idx;
	stp_status_t cur_status;
	logic [31:0] expiry_sum;
	logic [31:0] exp_rdata;
	logic [31:0] cmp_b;
	logic        cnt_lt;
	logic        ram_we;
	logic        running_now;

	assign req_ready = (state_q == S_IDLE);
	assign req_xfer  = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign slot_ext      = 7'(req.slot);
	assign slot_idx      = slot_ext[IW-1:0];
	assign slot_in_range = slot_ext < 7'(TIMER_SLOTS);
	assign idx_ext       = 7'(idx_q);

	// single status read port, always at the working index
	assign cur_status = status_q[idx_q];
	assign expiry_sum = cnt_q + 32'(period_q);

	// shared comparator: counter < expiry (new expiry during scan, stored one in query)
	assign cmp_b  = (state_q == S_SCAN) ? expiry_sum : exp_rdata;
	assign cnt_lt = cnt_q < cmp_b;

	assign ram_we = (state_q == S_SCAN) && (cur_status == ST_FREE);

	always_comb begin
		running_now = 1'b0;
		case (cur_status)
			ST_ACTIVE: running_now = cnt_lt;
			ST_WRAP:   running_now = (cnt_q > WRAP_GUARD) || cnt_lt;
			default:   running_now = 1'b0;
		endcase
	end

	stp_ram #(
		.WIDTH(32),
		.DEPTH(TIMER_SLOTS)
	) u_expiry (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata(expiry_sum),
		.raddr(idx_q),
		.rdata(exp_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_xfer) begin
					if (req.mode == MODE_ALLOC) begin
						state_d = S_SCAN;
					end else if (req.mode == MODE_QUERY && slot_in_range) begin
						state_d = S_QRD;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_SCAN: begin
				if (cur_status == ST_FREE || idx_q == LAST_IDX) begin
					state_d = S_DONE;
				end
			end
			S_QRD:  state_d = S_QCMP;
			S_QCMP: state_d = S_DONE;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control state: counter, slot states, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < TIMER_SLOTS; i++) begin
				status_q[i] <= ST_FREE;
			end
		end else begin
			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (req_xfer) begin
				case (req.mode)
					MODE_TICK:    cnt_q <= cnt_q + 32'd1;
					MODE_RESTART: cnt_q <= '0;
					MODE_RELEASE: begin
						if (slot_in_range) begin
							status_q[slot_idx] <= ST_FREE;
						end
					end
					default: ;
				endcase
			end
			// expiry not above the counter (period 0 included) marks a wrapped timer
			if (ram_we) begin
				status_q[idx_q] <= cnt_lt ? ST_ACTIVE : ST_WRAP;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			period_q   <= req.period;
			res_slot_q <= req.slot;
			res_run_q  <= 1'b0;
			if (req.mode == MODE_ALLOC) begin
				idx_q <= '0;
			end else begin
				idx_q <= slot_idx;
			end
			case (req.mode)
				MODE_TICK, MODE_RESTART: res_ok_q <= 1'b1;
				MODE_RELEASE, MODE_QUERY: res_ok_q <= slot_in_range;
				default: res_ok_q <= 1'b0;
			endcase
		end
		if (state_q == S_SCAN) begin
			if (cur_status == ST_FREE) begin
				res_ok_q   <= 1'b1;
				res_slot_q <= idx_ext[2:0];
			end else if (idx_q == LAST_IDX) begin
				res_ok_q   <= 1'b0;
				res_slot_q <= '0;
			end else begin
				idx_q <= idx_q + IW'(1);
			end
		end
		if (state_q == S_QCMP) begin
			res_run_q <= running_now;
		end
		if (state_q == S_DONE && out_free) begin
			rsp_q.ok           <= res_ok_q;
			rsp_q.granted_slot <= res_slot_q;
			rsp_q.running      <= res_run_q;
			rsp_q.tick_value   <= cnt_q;
		end
	end

endmodule

// ----- rtl/stp_checker.sv -----
// Port-level assertions for the software timer pool, bound to the top level.
`timescale 1ns / 1ps

module stp_checker
	import stp_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_ready,
	input stp_req_t req,
	input logic     rsp_valid,
	input logic     rsp_ready,
	input stp_rsp_t rsp
);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// one request at a time: ready drops right after a transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready stayed high after request transfer");

	// running is only ever reported by a successful query
	a_run_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.running |-> rsp.ok)
		else $error("running set without ok");

	// a fresh result never appears in the cycle after a request transfer
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !rsp_valid |=> !rsp_valid)
		else $error("result appeared too early");

endmodule

bind software_timer_pool_unit stp_checker u_stp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);

// ----- test/software_timer_pool_checker.sv -----
// Checker for the timer pool: predicts each response and compares it on transfer.
`timescale 1ns / 1ps

module software_timer_pool_checker
	import stp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic     req_ready,
	input  stp_req_t req,
	input  logic     rsp_valid,
	input  logic     rsp_ready,
	input  stp_rsp_t rsp,
	output int       errors,
	output int       outstanding,
	output int       checked,
	output int       full_cnt
);

	localparam int SLOTS = TIMER_SLOTS_DEF;

	logic [31:0] ticks_m;
	stp_status_t state_m [SLOTS];
	logic [31:0] expiry_m [SLOTS];
	stp_rsp_t    owed_rsp_q [$];

	function automatic logic slot_busy(input logic [2:0] s);
		case (state_m[s])
			ST_ACTIVE: return ticks_m < expiry_m[s];
			ST_WRAP:   return (ticks_m > WRAP_GUARD) || (ticks_m < expiry_m[s]);
			default:   return 1'b0;
		endcase
	endfunction

	// Applies one request to the shadow pool and returns the response it owes.
	function automatic stp_rsp_t pool_step(input stp_req_t r);
		stp_rsp_t    o;
		logic [31:0] e;
		bit          found;
		o.ok           = 1'b1;
		o.granted_slot = r.slot;
		o.running      = 1'b0;
		found          = 1'b0;
		case (stp_mode_t'(r.mode))
			MODE_TICK: ticks_m = ticks_m + 32'd1;
			MODE_ALLOC: begin
				o.ok           = 1'b0;
				o.granted_slot = '0;
				for (int i = 0; i < SLOTS; i++) begin
					if (!found && state_m[i] == ST_FREE) begin
						e              = ticks_m + {16'd0, r.period};
						expiry_m[i]    = e;
						state_m[i]     = (e > ticks_m) ? ST_ACTIVE : ST_WRAP;
						o.ok           = 1'b1;
						o.granted_slot = 3'(i);
						found          = 1'b1;
					end
				end
			end
			MODE_RELEASE: begin
				if (int'(r.slot) < SLOTS)
					state_m[r.slot] = ST_FREE;
				else
					o.ok = 1'b0;
			end
			MODE_QUERY: begin
				if (int'(r.slot) < SLOTS)
					o.running = slot_busy(r.slot);
				else
					o.ok = 1'b0;
			end
			MODE_RESTART: ticks_m = '0;
			default: o.ok = 1'b0;
		endcase
		o.tick_value = ticks_m;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		stp_rsp_t want;
		stp_rsp_t got;
		if (!arst_n) begin
			ticks_m = '0;
			foreach (state_m[i]) state_m[i] = ST_FREE;
			foreach (expiry_m[i]) expiry_m[i] = '0;
			owed_rsp_q.delete();
			outstanding <= 0;
		end else begin
			// responses first: a request taken on the same edge is always younger
			if (rsp_valid && rsp_ready) begin
				if (owed_rsp_q.size() == 0) begin
					$error("response with nothing outstanding, tick_value %0h", rsp.tick_value);
					errors++;
				end else begin
					want = owed_rsp_q.pop_front();
					checked++;
					if (rsp.ok !== want.ok) begin
						$error("ok: expected %0d, got %0d", want.ok, rsp.ok);
						errors++;
					end
					if (rsp.granted_slot !== want.granted_slot) begin
						$error("granted_slot: expected %0d, got %0d",
							want.granted_slot, rsp.granted_slot);
						errors++;
					end
					if (rsp.running !== want.running) begin
						$error("running: expected %0d, got %0d", want.running, rsp.running);
						errors++;
					end
					if (rsp.tick_value !== want.tick_value) begin
						$error("tick_value: expected %0h, got %0h",
							want.tick_value, rsp.tick_value);
						errors++;
					end
				end
			end
			if (req_valid && req_ready) begin
				got = pool_step(req);
				if (req.mode == MODE_ALLOC && !got.ok)
					full_cnt++;
				owed_rsp_q.push_back(got);
			end
			outstanding <= owed_rsp_q.size();
		end
	end

endmodule

// ----- test/software_timer_pool_unit_tb.sv -----
// Testbench top for the timer pool: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module software_timer_pool_unit_tb;
	import stp_pkg::*;

	localparam int RANDOM_PER_PHASE = 500;
	// Slowest legal item is a full allocate scan plus long idle runs on both
	// sides; 1500+ items fit well inside this bound.
	localparam int CYCLE_LIMIT      = 400000;
	localparam int DRAIN_CYCLES     = 16;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	stp_req_t req       = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	stp_rsp_t rsp;

	int errors;
	int outstanding;
	int checked;
	int full_cnt;

	int snd_idle_pct = 0;   // chance per cycle that the sender holds off
	int rcv_idle_pct = 0;   // chance per cycle that rsp_ready is low
	int cycles       = 0;
	int sent         = 0;

	software_timer_pool_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	software_timer_pool_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.errors      (errors),
		.outstanding (outstanding),
		.checked     (checked),
		.full_cnt    (full_cnt)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Receiver side: ready is redrawn every cycle, independent of rsp_valid.
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99, 0) >= rcv_idle_pct);
	end

	// Watchdog. Outstanding results at this point mean the block hung.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$error("watchdog hit after %0d cycles, %0d results outstanding",
				cycles, outstanding);
			$display("Regression FAIL");
			$finish;
		end
	end

	// One request transfer. A random hold-off drops valid first; with no
	// hold-off valid stays high and the payload simply moves on, so valid is
	// never lowered and raised in one step.
	task automatic send(input stp_req_t item);
		if ($urandom_range(99, 0) < snd_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99, 0) < snd_idle_pct);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		sent++;
	endtask

	task automatic issue(input logic [2:0] mode, input logic [2:0] slot,
			input logic [15:0] period);
		stp_req_t r;
		r.mode   = mode;
		r.slot   = slot;
		r.period = period;
		send(r);
	endtask

	// Stops the sender until every owed response is back. outstanding is
	// updated with a nonblocking write, so the first edge skip makes the
	// count include the transfer that just happened.
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// Mostly meaningful traffic: plenty of ticks so short timers actually
	// expire, allocate/release churn so the pool fills and empties, queries
	// against live timers, rare restarts and a few undefined modes.
	function automatic stp_req_t random_req();
		stp_req_t r;
		int       pick;
		int       pmix;
		pick     = $urandom_range(99, 0);
		pmix     = $urandom_range(9, 0);
		r.slot   = 3'($urandom_range(7, 0));
		if (pmix < 7)
			r.period = 16'($urandom_range(48, 0));
		else if (pmix == 7)
			r.period = ($urandom_range(1, 0) != 0) ? 16'hFFFF : 16'h0000;
		else
			r.period = 16'($urandom);
		if (pick < 35)
			r.mode = MODE_TICK;
		else if (pick < 55)
			r.mode = MODE_ALLOC;
		else if (pick < 70)
			r.mode = MODE_RELEASE;
		else if (pick < 90)
			r.mode = MODE_QUERY;
		else if (pick < 93)
			r.mode = MODE_RESTART;
		else
			r.mode = 3'($urandom_range(7, int'(MODE_RESTART) + 1));
		return r;
	endfunction

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. No query goes out until all eight slots have been
		// allocated, so every expiry entry is written before it is read.
		issue(MODE_TICK,    3'd7, 16'hFFFF);
		issue(MODE_RESTART, 3'd5, 16'h0000);
		issue(MODE_TICK,    3'd0, 16'h0000);
		issue(MODE_TICK,    3'd2, 16'h1234);
		issue(MODE_ALLOC,   3'd6, 16'h0000);  // zero period: wraps at allocate
		issue(MODE_ALLOC,   3'd0, 16'hFFFF);
		issue(MODE_ALLOC,   3'd1, 16'h0001);
		issue(MODE_ALLOC,   3'd7, 16'h0003);
		issue(MODE_ALLOC,   3'd3, 16'h0002);
		issue(MODE_ALLOC,   3'd4, 16'h8000);
		issue(MODE_ALLOC,   3'd5, 16'h7FFF);
		issue(MODE_ALLOC,   3'd2, 16'h5555);
		issue(MODE_ALLOC,   3'd7, 16'h000A);  // pool full
		issue(MODE_QUERY,   3'd0, 16'h0000);  // wrap slot, counter equals expiry
		issue(MODE_QUERY,   3'd1, 16'hFFFF);
		issue(MODE_TICK,    3'd4, 16'h0000);
		issue(MODE_QUERY,   3'd2, 16'h0000);  // expired exactly on this tick
		issue(MODE_RESTART, 3'd3, 16'hFFFF);
		issue(MODE_QUERY,   3'd0, 16'h0000);  // wrap slot runs again after restart
		issue(MODE_RELEASE, 3'd3, 16'h0000);
		issue(MODE_RELEASE, 3'd3, 16'hFFFF);  // release of a free slot
		issue(MODE_QUERY,   3'd3, 16'h0000);  // free slot never runs
		issue(MODE_ALLOC,   3'd0, 16'hAAAA);  // refills slot 3
		issue(3'(int'(MODE_RESTART) + 1), 3'd6, 16'h0000);  // undefined modes
		issue(3'(int'(MODE_RESTART) + 3), 3'd2, 16'hFFFF);
		issue(MODE_QUERY,   3'd7, 16'h0000);
		wait_drained();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					snd_idle_pct = 8;
					rcv_idle_pct = 79;
				end
				1: begin
					snd_idle_pct = 79;
					rcv_idle_pct = 8;
				end
				default: begin
					snd_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++)
				send(random_req());
			// full stop between phases, with the sender quiet until empty
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (outstanding != 0)
			$error("%0d responses never arrived", outstanding);

		$display("Covered %0d requests, %0d responses checked, %0d allocates on a full pool.",
			sent, checked, full_cnt);
		$display("Pacing ran sender-idle, receiver-idle and back-to-back phases, each drained.");
		if (errors == 0 && outstanding == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ----- software_timer_pool_unit.f -----
rtl/stp_pkg.sv
rtl/stp_ram.sv
rtl/software_timer_pool_unit.sv
rtl/stp_checker.sv
test/software_timer_pool_checker.sv
test/software_timer_pool_unit_tb.sv
